FILE: hdl/fpp_pkg.sv
// Shared constants, coefficient table and register indexes for the pedal percent filter.
package fpp_pkg;

    localparam int BASE_TAPS  = 21;
    localparam int COEF_MAX_W = 24;
    localparam int SMOOTH_W   = 17;
    localparam int PCT_W      = 14;
    localparam int REG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_W      = 31;
    localparam int DEN_W      = 17;

    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = 17'd131071;
    localparam logic [PCT_W-1:0]    PCT_FULL   = 14'd10000;

    localparam logic [REG_W-1:0] RELEASED_RESET = 13'd114;
    localparam logic [REG_W-1:0] FULL_RESET     = 13'd52;

    localparam logic [CFG_IDX_W-1:0] CFG_RELEASED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL     = 2'd1;

    typedef logic [15:0] t_q16;

    localparam t_q16 LP_Q16 [BASE_TAPS] = '{
        16'd269,  16'd400,  16'd734,  16'd1311, 16'd2110, 16'd3074, 16'd4109,
        16'd5092, 16'd5905, 16'd6442, 16'd6632, 16'd6442, 16'd5905, 16'd5092,
        16'd4109, 16'd3074, 16'd2110, 16'd1311, 16'd734,  16'd400,  16'd269
    };

    // Coefficient of one tap rescaled to coef_bits fraction bits, rounded half up.
    function automatic logic [COEF_MAX_W-1:0] fpp_coef(input logic [5:0] idx,
                                                       input int coef_bits);
        logic [COEF_MAX_W-1:0] c;
        c = '0;
        if (idx < 6'(BASE_TAPS)) begin
            c = COEF_MAX_W'(LP_Q16[idx[4:0]]);
        end
        if (coef_bits >= 16) begin
            c = c << (coef_bits - 16);
        end else begin
            c = (c + (COEF_MAX_W'(1) << (15 - coef_bits))) >> (16 - coef_bits);
        end
        return c;
    endfunction

endpackage

FILE: hdl/fpp_div.sv
// Restoring divider that produces one quotient bit per clock cycle.
module fpp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fpp_pkg::NUM_W-1:0]  i_num,
    input  logic [fpp_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [fpp_pkg::NUM_W-1:0]  o_quot
);
    import fpp_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   w_trial;
    logic             w_qbit;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_qbit  = (w_trial >= {1'b0, r_den});
        n_rem   = w_qbit ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(NUM_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[NUM_W-2:0], w_qbit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

FILE: hdl/fir_filtered_pedal_percent.sv
// Top level: symmetric low-pass FIR on range samples and map to brake pedal percent.
//
//   channel   direction  handshake             payload
//   sample    in         i_valid / o_ready     i_range_sample
//   result    out        o_valid / i_ready     o_smoothed_range, o_pedal_percent
//   config    in         i_cfg_we              i_cfg_index, i_cfg_data
//
// A word passes through S_MAC, S_LAST, S_ROUND, S_SAT, S_CLAMP, S_MUL, S_DIV and S_DONE,
// and the next word is taken only once the filter is back in S_IDLE.
// A single multiply-accumulate unit visits one tap per cycle over a rotating delay line,
// and the percentage divide yields one quotient bit per cycle.
// A new word is taken only while the filter is idle; a finished result moves to the
// output register, and if that register still holds an unread word it waits and the
// input stalls.
// Reset is synchronous, clears the delay line and loads the default pedal distances.
module fir_filtered_pedal_percent #(
    parameter int TAP_COUNT   = 21,
    parameter int SAMPLE_BITS = 13,
    parameter int COEF_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [SAMPLE_BITS-1:0]            i_range_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [fpp_pkg::SMOOTH_W-1:0]      o_smoothed_range,
    output logic [fpp_pkg::PCT_W-1:0]         o_pedal_percent,
    input  logic                              i_cfg_we,
    input  logic [fpp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fpp_pkg::REG_W-1:0]         i_cfg_data
);
    import fpp_pkg::*;

    localparam int IDX_W  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 6;
    localparam int SH     = COEF_BITS - 4;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (SH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MAC, S_LAST, S_ROUND, S_SAT, S_CLAMP, S_MUL, S_DIV, S_DONE
    } t_state;

    t_state                  r_state;
    logic [SAMPLE_BITS-1:0]  r_line [TAP_COUNT];
    logic [IDX_W-1:0]        r_tap;
    logic [PROD_W-1:0]       r_prod;
    logic [ACC_W-1:0]        r_acc;
    logic [REG_W-1:0]        r_released;
    logic [REG_W-1:0]        r_full;
    logic [SMOOTH_W-1:0]     r_smooth;
    logic [DEN_W-1:0]        r_diff;
    logic [DEN_W-1:0]        r_span;
    logic                    r_pos;
    logic [NUM_W-1:0]        r_num;
    logic                    r_div_start;
    logic                    r_o_valid;
    logic [SMOOTH_W-1:0]     r_o_smooth;
    logic [PCT_W-1:0]        r_o_pct;

    logic                    w_accept;
    logic [COEF_BITS-1:0]    w_coef;
    logic [ACC_W-1:0]        w_scaled;
    logic [DEN_W-1:0]        w_rel16;
    logic [DEN_W-1:0]        w_full16;
    logic [DEN_W-1:0]        w_clamped;
    logic [NUM_W-1:0]        w_scaled_diff;
    logic                    w_div_done;
    logic [NUM_W-1:0]        w_quot;
    logic                    w_load;

    fpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_span),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        w_accept      = i_valid && (r_state == S_IDLE);
        w_coef        = COEF_BITS'(fpp_coef(6'(r_tap), COEF_BITS));
        w_scaled      = r_acc >> SH;
        w_rel16       = {r_released, 4'b0000};
        w_full16      = {r_full, 4'b0000};
        if (r_smooth > w_rel16) begin
            w_clamped = w_rel16;
        end else if (r_smooth < w_full16) begin
            w_clamped = w_full16;
        end else begin
            w_clamped = r_smooth;
        end
        w_scaled_diff = NUM_W'(r_diff) * NUM_W'(PCT_FULL);
        w_load        = (r_state == S_DONE) && (!r_o_valid || i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_released  <= RELEASED_RESET;
            r_full      <= FULL_RESET;
            r_div_start <= 1'b0;
            r_o_valid   <= 1'b0;
            r_tap       <= '0;
            for (int i = 0; i < TAP_COUNT; i++) begin
                r_line[i] <= '0;
            end
        end else begin
            r_div_start <= (r_state == S_MUL);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RELEASED: r_released <= i_cfg_data;
                    CFG_FULL:     r_full     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_o_valid && i_ready && !w_load) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_line[0] <= i_range_sample;
                        for (int i = 1; i < TAP_COUNT; i++) begin
                            r_line[i] <= r_line[i-1];
                        end
                        r_tap   <= '0;
                        r_prod  <= '0;
                        r_acc   <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_prod <= PROD_W'(w_coef) * PROD_W'(r_line[0]);
                    r_acc  <= r_acc + ACC_W'(r_prod);
                    for (int i = 0; i < TAP_COUNT - 1; i++) begin
                        r_line[i] <= r_line[i+1];
                    end
                    r_line[TAP_COUNT-1] <= r_line[0];
                    if (r_tap == IDX_W'(TAP_COUNT - 1)) begin
                        r_state <= S_LAST;
                    end else begin
                        r_tap <= r_tap + 1'b1;
                    end
                end
                S_LAST: begin
                    r_acc   <= r_acc + ACC_W'(r_prod);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_acc   <= r_acc + HALF;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (w_scaled > ACC_W'(SMOOTH_MAX)) begin
                        r_smooth <= SMOOTH_MAX;
                    end else begin
                        r_smooth <= SMOOTH_W'(w_scaled);
                    end
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_diff  <= w_rel16 - w_clamped;
                    r_span  <= w_rel16 - w_full16;
                    r_pos   <= (w_rel16 > w_full16);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_num       <= w_scaled_diff + NUM_W'(r_span >> 1);
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_o_valid  <= 1'b1;
                        r_o_smooth <= r_smooth;
                        r_o_pct    <= r_pos ? PCT_W'(w_quot) : '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_smoothed_range = r_o_smooth;
    assign o_pedal_percent  = r_o_pct;

    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MAC))
        else $error("accepted word did not start the accumulation");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_tap <= IDX_W'(TAP_COUNT - 1)))
        else $error("tap counter ran past the last tap");

    a_done_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_o_valid && (r_state == S_IDLE)))
        else $error("finished result was not presented");

    a_pct_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_pct <= PCT_FULL))
        else $error("pedal percent above full travel");

endmodule

FILE: bench/fir_filtered_pedal_percent_tb.sv
// Self-checking testbench for the pedal percent filter, with an FIR and percent predictor.
module fir_filtered_pedal_percent_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpp_pkg::*;

    localparam int TAP_COUNT     = 21;
    localparam int SAMPLE_BITS   = 13;
    localparam int COEF_BITS     = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_WORDS   = 100;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_AT      = 480;
    localparam int STALL_CYCLES  = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [SMOOTH_W-1:0] smooth;
        logic [PCT_W-1:0]    pct;
    } pedal_result_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [7:0]             reps;
        logic                   known;
        logic [SMOOTH_W-1:0]    smooth;
        logic [PCT_W-1:0]       pct;
    } directed_row_t;

    // The expected values only apply to the last repetition of a row, and only where known is set.
    localparam int DIRECTED_ROWS = 6;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{13'd0,    8'd1,  1'b1, 17'd0,      14'd10000},
        '{13'd8191, 8'd20, 1'b0, 17'd0,      14'd0},
        '{13'd8191, 8'd1,  1'b1, 17'd131032, 14'd0},
        '{13'd5461, 8'd1,  1'b0, 17'd0,      14'd0},
        '{13'd2730, 8'd1,  1'b0, 17'd0,      14'd0},
        '{13'd1,    8'd1,  1'b0, 17'd0,      14'd0}
    };

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic                   o_ready;
    logic [SAMPLE_BITS-1:0] i_range_sample = '0;
    logic                   o_valid;
    logic                   i_ready        = 1'b0;
    logic [SMOOTH_W-1:0]    o_smoothed_range;
    logic [PCT_W-1:0]       o_pedal_percent;
    logic                   i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index    = '0;
    logic [REG_W-1:0]       i_cfg_data     = '0;

    logic [SAMPLE_BITS-1:0] range_line [TAP_COUNT] = '{default: '0};
    logic [REG_W-1:0]       model_released = RELEASED_RESET;
    logic [REG_W-1:0]       model_full     = FULL_RESET;
    pedal_result_t          pending_results [$];
    int                     fail_count = 0;
    int                     words_out  = 0;
    bit                     no_idle    = 1'b0;

    fir_filtered_pedal_percent #(
        .TAP_COUNT   (TAP_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_range_sample   (i_range_sample),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_smoothed_range (o_smoothed_range),
        .o_pedal_percent  (o_pedal_percent),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic pedal_result_t predict_pedal(input logic [SAMPLE_BITS-1:0] sample);
        logic [63:0]   acc;
        logic [63:0]   smooth;
        logic [63:0]   rel16;
        logic [63:0]   full16;
        logic [63:0]   clamped;
        logic [63:0]   span;
        logic [63:0]   pct;
        pedal_result_t res;
        for (int i = TAP_COUNT - 1; i > 0; i--) begin
            range_line[i] = range_line[i-1];
        end
        range_line[0] = sample;
        acc = '0;
        for (int i = 0; i < TAP_COUNT; i++) begin
            acc += 64'(fpp_coef(6'(i), COEF_BITS)) * 64'(range_line[i]);
        end
        smooth = (acc + (64'd1 << (COEF_BITS - 5))) >> (COEF_BITS - 4);
        if (smooth > 64'(SMOOTH_MAX)) begin
            smooth = 64'(SMOOTH_MAX);
        end
        rel16  = 64'(model_released) * 64'd16;
        full16 = 64'(model_full) * 64'd16;
        pct    = '0;
        if (rel16 > full16) begin
            clamped = smooth;
            if (clamped > rel16) begin
                clamped = rel16;
            end else if (clamped < full16) begin
                clamped = full16;
            end
            span = rel16 - full16;
            pct  = ((rel16 - clamped) * 64'(PCT_FULL) + span / 2) / span;
            if (pct > 64'(PCT_FULL)) begin
                pct = 64'(PCT_FULL);
            end
        end
        res.smooth = smooth[SMOOTH_W-1:0];
        res.pct    = pct[PCT_W-1:0];
        return res;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] next_sample(input logic [SAMPLE_BITS-1:0] lo,
                                                           input logic [SAMPLE_BITS-1:0] hi,
                                                           input logic [SAMPLE_BITS-1:0] prev);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return SAMPLE_BITS'($urandom_range(hi, lo));
        end else if (pick < 65) begin
            return prev;
        end else if (pick < 80) begin
            return SAMPLE_BITS'($urandom);
        end else if (pick < 90) begin
            return pick[0] ? '1 : '0;
        end
        return (pick[0] ? lo : hi) + SAMPLE_BITS'($urandom_range(0, 3));
    endfunction

    task automatic send_word(input logic [SAMPLE_BITS-1:0] sample, input pedal_result_t known,
                             input bit use_known);
        int            gap;
        pedal_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_range_sample <= sample;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_pedal(sample);
        pending_results.push_back(use_known ? known : predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx == CFG_RELEASED) begin
            model_released = data;
        end else if (idx == CFG_FULL) begin
            model_full = data;
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int            gap;
        pedal_result_t want;
        wait (i_rst_n);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (words_out == STALL_AT) begin
                gap = STALL_CYCLES;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            words_out++;
            if (pending_results.size() == 0) begin
                $error("unexpected word: smoothed_range %0d, pedal_percent %0d",
                       o_smoothed_range, o_pedal_percent);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_smoothed_range !== want.smooth) begin
                    $error("smoothed_range: expected %0d, actual %0d",
                           want.smooth, o_smoothed_range);
                    fail_count++;
                end
                if (o_pedal_percent !== want.pct) begin
                    $error("pedal_percent: expected %0d, actual %0d",
                           want.pct, o_pedal_percent);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic [REG_W-1:0]       rel_set  [PHASES];
        logic [REG_W-1:0]       full_set [PHASES];
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] sample;
        pedal_result_t          known;

        rel_set[0] = 13'd8191;        full_set[0] = 13'd0;
        rel_set[1] = 13'd0;           full_set[1] = 13'd8191;
        rel_set[2] = 13'd2000;        full_set[2] = 13'd2000;
        rel_set[3] = RELEASED_RESET;  full_set[3] = FULL_RESET;
        rel_set[4] = 13'd0;           full_set[4] = 13'd0;
        rel_set[5] = 13'd8191;        full_set[5] = 13'd8190;
        rel_set[6] = REG_W'($urandom_range(1, 8191));
        full_set[6] = REG_W'($urandom_range(0, rel_set[6] - 1));
        rel_set[7] = REG_W'($urandom);
        full_set[7] = REG_W'($urandom);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            for (int k = 0; k < DIRECTED[r].reps; k++) begin
                known.smooth = DIRECTED[r].smooth;
                known.pct    = DIRECTED[r].pct;
                send_word(DIRECTED[r].sample, known,
                          DIRECTED[r].known && (k == DIRECTED[r].reps - 1));
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_reg(CFG_RELEASED, rel_set[p]);
            write_reg(CFG_FULL, full_set[p]);
            write_reg(p[0] ? CFG_SPARE_B : CFG_SPARE_A, REG_W'($urandom));
            i_cfg_we <= 1'b0;
            lo = (rel_set[p] < full_set[p]) ? rel_set[p] : full_set[p];
            hi = (rel_set[p] < full_set[p]) ? full_set[p] : rel_set[p];
            sample = lo;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 25 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                sample = next_sample(lo, hi, sample);
                send_word(sample, '0, 1'b0);
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
